@@ hdl/bmh_pkg.sv @@
// Shared types, constants and compare function for the two-key binary min-heap.
package bmh_pkg;

    // Heap geometry
    localparam int HEAP_DEPTH = 1024;
    localparam int POS_W      = $clog2(HEAP_DEPTH + 1);
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);

    // Field widths, fixed by the port list
    localparam int PRI_W    = 11;
    localparam int SEC_W    = 16;
    localparam int PAY_W    = 10;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;

    // Queue depths between the parts
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [POS_W:0]    t_cpos;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [SEC_W-1:0] sec;
        logic [PAY_W-1:0] pay;
    } t_entry;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op    op;
        t_entry ent;
    } t_cmd;

    typedef struct packed {
        t_entry  ent;
        t_status status;
        t_pos    count;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_LD,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_RESULT
    } t_state;

    // True when a orders strictly after b
    function automatic logic is_larger(t_entry a, t_entry b);
        logic res;
        if (a.pri == b.pri) begin
            res = (a.sec > b.sec);
        end else begin
            res = (a.pri > b.pri);
        end
        return res;
    endfunction

endpackage

@@ hdl/bmh_front.sv @@
// Front part: takes input beats, decodes the action and queues commands.
module bmh_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_action,
    input  logic [bmh_pkg::PRI_W-1:0]   i_key_primary,
    input  logic [bmh_pkg::SEC_W-1:0]   i_key_secondary,
    input  logic [bmh_pkg::PAY_W-1:0]   i_payload,
    output logic                        o_cmd_valid,
    output bmh_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_take
);

    bmh_pkg::t_cmd                  r_slot [bmh_pkg::CMDQ_DEPTH];
    logic [bmh_pkg::CMDQ_PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [bmh_pkg::CMDQ_PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [bmh_pkg::CMDQ_CW-1:0]    r_cnt, n_cnt;
    logic                           wr_en;
    logic                           rd_en;
    bmh_pkg::t_cmd                  cmd_in;

    // Decode the beat into a command
    always_comb begin
        cmd_in.op      = i_action ? bmh_pkg::OP_POP : bmh_pkg::OP_PUSH;
        cmd_in.ent.pri = i_key_primary;
        cmd_in.ent.sec = i_key_secondary;
        cmd_in.ent.pay = i_payload;
    end

    assign full        = (r_cnt == bmh_pkg::CMDQ_CW'(bmh_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == bmh_pkg::CMDQ_PW'(bmh_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == bmh_pkg::CMDQ_PW'(bmh_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

@@ hdl/bmh_back.sv @@
// Back part: heap memory and the sequencer that sifts entries up and down.
module bmh_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  bmh_pkg::t_cmd       i_cmd,
    output logic                o_cmd_take,
    input  logic                i_res_full,
    output logic                o_res_push,
    output bmh_pkg::t_result    o_res
);

    // Heap store, position p lives at address p-1
    bmh_pkg::t_entry    r_heap [bmh_pkg::HEAP_DEPTH];
    bmh_pkg::t_entry    r_rd_a, r_rd_b;

    bmh_pkg::t_state    r_state, n_state;
    bmh_pkg::t_pos      r_count, n_count;
    bmh_pkg::t_pos      r_pos, n_pos;
    bmh_pkg::t_entry    r_ent, n_ent;
    bmh_pkg::t_entry    r_out, n_out;
    bmh_pkg::t_status   r_status, n_status;

    logic               mem_we;
    bmh_pkg::t_addr     mem_wa;
    bmh_pkg::t_entry    mem_wd;
    bmh_pkg::t_addr     mem_ra_a;
    bmh_pkg::t_addr     mem_ra_b;

    bmh_pkg::t_cpos     child_l, child_r;
    logic               lin, rin;
    logic               pl, pr, rl;
    logic               go_l, go_r;
    logic               push_up;
    logic               is_full, is_empty, more_below;

    // Compare terms
    always_comb begin
        child_l    = {r_pos, 1'b0};
        child_r    = child_l + 1'b1;
        lin        = (child_l <= {1'b0, r_count});
        rin        = (child_r <= {1'b0, r_count});
        pl         = bmh_pkg::is_larger(r_ent, r_rd_a);
        pr         = bmh_pkg::is_larger(r_ent, r_rd_b);
        rl         = bmh_pkg::is_larger(r_rd_b, r_rd_a);
        go_r       = rin && pr && !rl;
        go_l       = !go_r && lin && pl;
        push_up    = bmh_pkg::is_larger(r_rd_a, r_ent);
        is_full    = (r_count == bmh_pkg::POS_W'(bmh_pkg::HEAP_DEPTH));
        is_empty   = (r_count == '0);
        more_below = (r_pos < r_count);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmh_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == bmh_pkg::OP_PUSH) begin
                        n_state = is_full ? bmh_pkg::S_RESULT : bmh_pkg::S_PUSH_RD;
                    end else begin
                        n_state = is_empty ? bmh_pkg::S_RESULT : bmh_pkg::S_POP_LD;
                    end
                end
            end
            bmh_pkg::S_PUSH_RD: begin
                n_state = (r_pos == bmh_pkg::POS_W'(1)) ?
                          bmh_pkg::S_RESULT : bmh_pkg::S_PUSH_CMP;
            end
            bmh_pkg::S_PUSH_CMP: begin
                n_state = push_up ? bmh_pkg::S_PUSH_RD : bmh_pkg::S_RESULT;
            end
            bmh_pkg::S_POP_LD: begin
                n_state = bmh_pkg::S_DOWN_RD;
            end
            bmh_pkg::S_DOWN_RD: begin
                n_state = more_below ? bmh_pkg::S_DOWN_CMP : bmh_pkg::S_RESULT;
            end
            bmh_pkg::S_DOWN_CMP: begin
                n_state = (go_r || go_l) ? bmh_pkg::S_DOWN_RD : bmh_pkg::S_RESULT;
            end
            bmh_pkg::S_RESULT: begin
                if (!i_res_full) begin
                    n_state = bmh_pkg::S_IDLE;
                end
            end
            default: n_state = bmh_pkg::S_IDLE;
        endcase
    end

    // Memory controls and handshakes
    always_comb begin
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = bmh_pkg::ADDR_W'(r_pos - 1'b1);
        mem_wd     = r_ent;
        mem_ra_a   = '0;
        mem_ra_b   = '0;
        unique case (r_state)
            bmh_pkg::S_IDLE: begin
                // fetch root and last entry ahead of a pop
                o_cmd_take = i_cmd_valid;
                mem_ra_b   = bmh_pkg::ADDR_W'(r_count - 1'b1);
            end
            bmh_pkg::S_PUSH_RD: begin
                if (r_pos == bmh_pkg::POS_W'(1)) begin
                    mem_we = 1'b1;
                end else begin
                    mem_ra_a = bmh_pkg::ADDR_W'((r_pos >> 1) - 1'b1);
                end
            end
            bmh_pkg::S_PUSH_CMP: begin
                mem_we = 1'b1;
                mem_wd = push_up ? r_rd_a : r_ent;
            end
            bmh_pkg::S_POP_LD: begin
            end
            bmh_pkg::S_DOWN_RD: begin
                if (more_below) begin
                    mem_ra_a = bmh_pkg::ADDR_W'(child_l - 1'b1);
                    mem_ra_b = bmh_pkg::ADDR_W'(child_r - 1'b1);
                end else begin
                    mem_we = 1'b1;
                end
            end
            bmh_pkg::S_DOWN_CMP: begin
                mem_we = 1'b1;
                if (go_r) begin
                    mem_wd = r_rd_b;
                end else if (go_l) begin
                    mem_wd = r_rd_a;
                end
            end
            bmh_pkg::S_RESULT: begin
                o_res_push = !i_res_full;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_ent    = r_ent;
        n_out    = r_out;
        n_status = r_status;
        unique case (r_state)
            bmh_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_out    = '0;
                    n_status = bmh_pkg::ST_DONE;
                    if (i_cmd.op == bmh_pkg::OP_PUSH) begin
                        if (is_full) begin
                            n_status = bmh_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_pos   = r_count + 1'b1;
                            n_ent   = i_cmd.ent;
                        end
                    end else begin
                        if (is_empty) begin
                            n_status = bmh_pkg::ST_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
            end
            bmh_pkg::S_PUSH_CMP: begin
                if (push_up) begin
                    n_pos = r_pos >> 1;
                end
            end
            bmh_pkg::S_POP_LD: begin
                // root goes out, last entry starts at the top
                n_out = r_rd_a;
                n_ent = r_rd_b;
                n_pos = bmh_pkg::POS_W'(1);
            end
            bmh_pkg::S_DOWN_CMP: begin
                if (go_r) begin
                    n_pos = bmh_pkg::POS_W'(child_r);
                end else if (go_l) begin
                    n_pos = bmh_pkg::POS_W'(child_l);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmh_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_ent    <= n_ent;
        r_out    <= n_out;
        r_status <= n_status;
    end

    // Heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_heap[mem_ra_a];
        r_rd_b <= r_heap[mem_ra_b];
    end

    always_comb begin
        o_res.ent    = r_out;
        o_res.status = r_status;
        o_res.count  = r_count;
    end

endmodule

@@ hdl/bmh_res_q.sv @@
// Result queue between the heap sequencer and the output ports.
module bmh_res_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_push,
    input  bmh_pkg::t_result    i_res,
    output logic                o_res_full,
    output logic                empty,
    input  logic                pop,
    output bmh_pkg::t_result    o_res
);

    bmh_pkg::t_result               r_slot [bmh_pkg::RESQ_DEPTH];
    logic [bmh_pkg::RESQ_PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [bmh_pkg::RESQ_PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [bmh_pkg::RESQ_CW-1:0]    r_cnt, n_cnt;
    logic                           wr_en;
    logic                           rd_en;

    assign o_res_full = (r_cnt == bmh_pkg::RESQ_CW'(bmh_pkg::RESQ_DEPTH));
    assign empty      = (r_cnt == '0);
    assign o_res      = r_slot[r_rd_ptr];
    assign wr_en      = i_res_push && !o_res_full;
    assign rd_en      = pop && !empty;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == bmh_pkg::RESQ_PW'(bmh_pkg::RESQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == bmh_pkg::RESQ_PW'(bmh_pkg::RESQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

@@ hdl/binary_min_heap_two_key_core.sv @@
// Two-key binary min-heap priority queue, top level.
// Push beats add an entry, pop beats remove the smallest (primary key, then
// secondary key); every input beat gives exactly one result beat carrying the
// popped entry (zero for pushes), a status (done, pop on empty, push on full)
// and the entry count afterwards. Beats are taken into a two-deep command
// queue and results leave through a two-deep result queue, so both sides may
// stall freely. One operation is carried out at a time by the heap sequencer
// against a 1024 x 37 memory with one write and two registered read ports:
// a push reads and compares the parent once per level it climbs, a pop loads
// the root and last entry, then reads and compares both children once per
// level it sinks; refused operations go straight to the result. The heap
// memory needs no clearing after reset.
module binary_min_heap_two_key_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_action,
    input  logic [bmh_pkg::PRI_W-1:0]       i_key_primary,
    input  logic [bmh_pkg::SEC_W-1:0]       i_key_secondary,
    input  logic [bmh_pkg::PAY_W-1:0]       i_payload,
    output logic                            empty,
    input  logic                            pop,
    output logic [bmh_pkg::PRI_W-1:0]       o_out_primary,
    output logic [bmh_pkg::SEC_W-1:0]       o_out_secondary,
    output logic [bmh_pkg::PAY_W-1:0]       o_out_payload,
    output logic [bmh_pkg::STATUS_W-1:0]    o_status,
    output logic [bmh_pkg::CNT_W-1:0]       o_count
);

    logic               cmd_valid;
    bmh_pkg::t_cmd      cmd;
    logic               cmd_take;
    logic               res_push;
    logic               res_full;
    bmh_pkg::t_result   res_in;
    bmh_pkg::t_result   res_out;

    bmh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_key_primary   (i_key_primary),
        .i_key_secondary (i_key_secondary),
        .i_payload       (i_payload),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_take      (cmd_take)
    );

    bmh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    bmh_res_q u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res_in),
        .o_res_full (res_full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res_out)
    );

    // Result fields onto the ports
    assign o_out_primary   = res_out.ent.pri;
    assign o_out_secondary = res_out.ent.sec;
    assign o_out_payload   = res_out.ent.pay;
    assign o_status        = res_out.status;
    assign o_count         = bmh_pkg::t_count'(res_out.count);

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the two-key binary min-heap core.
`timescale 1ns / 100ps

module tb;
    import bmh_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_OPS  = 375;
    localparam int GAP_MAX     = 18;
    localparam int HOLD_AFTER  = 60;   // results seen before the long receiver stall
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 40;

    // Clock, reset and block ports
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               push            = 1'b0;
    logic               full;
    logic               i_action        = 1'b0;
    logic [PRI_W-1:0]   i_key_primary   = '0;
    logic [SEC_W-1:0]   i_key_secondary = '0;
    logic [PAY_W-1:0]   i_payload       = '0;
    logic               empty;
    logic               pop             = 1'b0;
    logic [PRI_W-1:0]   o_out_primary;
    logic [SEC_W-1:0]   o_out_secondary;
    logic [PAY_W-1:0]   o_out_payload;
    logic [STATUS_W-1:0] o_status;
    logic [CNT_W-1:0]   o_count;

    binary_min_heap_two_key_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_key_primary   (i_key_primary),
        .i_key_secondary (i_key_secondary),
        .i_payload       (i_payload),
        .empty           (empty),
        .pop             (pop),
        .o_out_primary   (o_out_primary),
        .o_out_secondary (o_out_secondary),
        .o_out_payload   (o_out_payload),
        .o_status        (o_status),
        .o_count         (o_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Heap shadow: its own entry store and fill level
    t_entry      heap_shadow [1:HEAP_DEPTH];
    int unsigned heap_len = 0;

    // Beats still to send, and results still owed by the block
    t_cmd    cmd_backlog[$];
    t_result owed_results[$];

    // Handshake flags sampled at the rising edge, used at the falling edge
    bit tx_taken = 1'b0;
    bit rx_taken = 1'b0;

    // Run statistics
    int          errors       = 0;
    int unsigned results_seen = 0;
    int unsigned cycles       = 0;
    int unsigned n_push       = 0;
    int unsigned n_pop        = 0;
    int unsigned n_full_ref   = 0;
    int unsigned n_empty_ref  = 0;
    int unsigned max_len      = 0;

    // Sort order: primary key first, secondary key breaks ties
    function automatic logic [PRI_W+SEC_W-1:0] order_key(input t_entry e);
        return {e.pri, e.sec};
    endfunction

    function automatic bit after(input t_entry a, input t_entry b);
        return order_key(a) > order_key(b);
    endfunction

    // Apply one operation to the shadow heap and return the result it owes
    function automatic t_result heap_apply(input t_cmd c);
        t_result     res;
        t_entry      tmp;
        int unsigned pos;
        int unsigned l;
        int unsigned r;
        bit          lin;
        bit          rin;
        res = '0;
        res.status = ST_DONE;
        if (c.op == OP_PUSH) begin
            n_push++;
            if (heap_len >= HEAP_DEPTH) begin
                res.status = ST_FULL;
                n_full_ref++;
            end else begin
                heap_len++;
                pos = heap_len;
                // sift up, stop at the first parent that is not larger
                while (pos > 1 && after(heap_shadow[pos/2], c.ent)) begin
                    heap_shadow[pos] = heap_shadow[pos/2];
                    pos = pos / 2;
                end
                heap_shadow[pos] = c.ent;
                if (heap_len > max_len) max_len = heap_len;
            end
        end else begin
            n_pop++;
            if (heap_len == 0) begin
                res.status = ST_EMPTY;
                n_empty_ref++;
            end else begin
                res.ent = heap_shadow[1];
                heap_shadow[1] = heap_shadow[heap_len];
                heap_len--;
                pos = 1;
                // sift down; right child wins when not larger than the left
                while (pos < heap_len) begin
                    l   = pos * 2;
                    r   = l + 1;
                    lin = (l <= heap_len);
                    rin = (r <= heap_len);
                    if (lin && rin && !after(heap_shadow[pos], heap_shadow[l])
                        && !after(heap_shadow[pos], heap_shadow[r])) begin
                        break;
                    end else if (rin && after(heap_shadow[pos], heap_shadow[r])
                        && !after(heap_shadow[r], heap_shadow[l])) begin
                        tmp = heap_shadow[pos];
                        heap_shadow[pos] = heap_shadow[r];
                        heap_shadow[r] = tmp;
                        pos = r;
                    end else if (lin && after(heap_shadow[pos], heap_shadow[l])) begin
                        tmp = heap_shadow[pos];
                        heap_shadow[pos] = heap_shadow[l];
                        heap_shadow[l] = tmp;
                        pos = l;
                    end else begin
                        break;
                    end
                end
            end
        end
        res.count = heap_len[POS_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    // Sample both handshakes; predict on input beats, check on result beats
    always @(posedge i_clk) begin
        t_cmd    seen_cmd;
        t_result want;
        tx_taken = i_rst_n && push && !full;
        rx_taken = i_rst_n && pop && !empty;
        if (tx_taken) begin
            seen_cmd.op      = t_op'(i_action);
            seen_cmd.ent.pri = i_key_primary;
            seen_cmd.ent.sec = i_key_secondary;
            seen_cmd.ent.pay = i_payload;
            owed_results.push_back(heap_apply(seen_cmd));
        end
        if (rx_taken) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("result beat with nothing owed: primary %0d count %0d",
                       o_out_primary, o_count);
                errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("out_primary",   want.ent.pri, o_out_primary);
                check_field("out_secondary", want.ent.sec, o_out_secondary);
                check_field("out_payload",   want.ent.pay, o_out_payload);
                check_field("status",        want.status,  o_status);
                check_field("count",         want.count,   o_count);
            end
        end
    end

    // Driver: takes beats from the backlog, random gaps between them
    t_cmd        cur_cmd;
    bit          have_cur = 1'b0;
    bit          tx_burst = 1'b0;
    int unsigned tx_gap   = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (tx_taken) begin
                have_cur = 1'b0;
                if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!have_cur) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (cmd_backlog.size() > 0) begin
                    cur_cmd  = cmd_backlog.pop_front();
                    have_cur = 1'b1;
                end
            end
            push            <= have_cur;
            i_action        <= cur_cmd.op;
            i_key_primary   <= cur_cmd.ent.pri;
            i_key_secondary <= cur_cmd.ent.sec;
            i_payload       <= cur_cmd.ent.pay;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    bit          rx_burst   = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned rx_gap     = 0;
    int unsigned hold_left  = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_taken) begin
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped by the cycle limit, %0d results still owed",
                     owed_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input t_op op, input int unsigned pri,
                                      input int unsigned sec, input int unsigned pay);
        t_cmd c;
        c.op      = op;
        c.ent.pri = PRI_W'(pri);
        c.ent.sec = SEC_W'(sec);
        c.ent.pay = PAY_W'(pay);
        return c;
    endfunction

    // Random keys: many ties, the legal range, and the full field width
    function automatic t_cmd rand_cmd(input t_op op);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return make_cmd(op, $urandom_range(0, 15), $urandom_range(0, 3),
                            $urandom_range(0, 1023));
        end else if (pick < 8) begin
            return make_cmd(op, $urandom_range(0, 1024), $urandom_range(0, 65535),
                            $urandom_range(0, 1023));
        end
        return make_cmd(op, $urandom(), $urandom(), $urandom());
    endfunction

    function automatic void queue_cmd(input t_cmd c);
        cmd_backlog.push_back(c);
    endfunction

    // Stimulus, reset and end of run
    initial begin
        int i;
        int push_pct;

        // directed: pop on empty, extreme keys, equal keys
        queue_cmd(make_cmd(OP_POP, 0, 0, 0));
        queue_cmd(make_cmd(OP_PUSH, 11'h7FF, 16'hFFFF, 10'h3FF));
        queue_cmd(make_cmd(OP_PUSH, 1024, 0, 1023));
        queue_cmd(make_cmd(OP_PUSH, 0, 16'hFFFF, 0));
        queue_cmd(make_cmd(OP_PUSH, 0, 0, 10'h155));
        queue_cmd(make_cmd(OP_PUSH, 0, 0, 10'h2AA));
        queue_cmd(make_cmd(OP_PUSH, 5, 100, 1));
        queue_cmd(make_cmd(OP_PUSH, 5, 99, 2));
        repeat (8) queue_cmd(make_cmd(OP_POP, 0, 0, 0));
        // sift-down with equal children: the right one must rise
        queue_cmd(make_cmd(OP_PUSH, 1, 0, 4));
        queue_cmd(make_cmd(OP_PUSH, 7, 7, 5));
        queue_cmd(make_cmd(OP_PUSH, 7, 7, 6));
        queue_cmd(make_cmd(OP_PUSH, 9, 9, 7));
        repeat (5) queue_cmd(make_cmd(OP_POP, 0, 0, 0));

        // random mix, push bias changing every 50 beats
        push_pct = 50;
        for (i = 0; i < RANDOM_OPS; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        push_pct = 75;
                    end
                    1: begin
                        push_pct = 50;
                    end
                    default: begin
                        push_pct = 30;
                    end
                endcase
            end
            queue_cmd(rand_cmd(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP));
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || have_cur) @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d pushes and %0d pops, %0d result beats checked, peak fill %0d",
                 n_push, n_pop, results_seen, max_len);
        $display("Refused beats: %0d push on full, %0d pop on empty",
                 n_full_ref, n_empty_ref);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/bmh_pkg.sv
hdl/bmh_front.sv
hdl/bmh_back.sv
hdl/bmh_res_q.sv
hdl/binary_min_heap_two_key_core.sv
tb/sv/tb.sv
